// ----- rtl/tmsc_pkg.sv -----
// ----------------------------------------------------------------------------
// tmsc_pkg
// Shared constants, status codes, the column record and a saturating add of the top-5 scanner.
// ----------------------------------------------------------------------------
package tmsc_pkg;

  localparam int TOP_COUNT      = 5;
  localparam int MAX_CANDIDATES = 65536;
  localparam int RANK_W         = 17;
  localparam int SLOT_W         = $clog2(TOP_COUNT);
  localparam int IDX_W          = 16;
  localparam int VAL_W          = 32;
  localparam int QDEPTH         = 2;
  localparam int QPTR_W         = $clog2(QDEPTH);
  localparam int QCNT_W         = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W      = 1;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t EMPTY_SCORE   = -32'sd655294464;
  localparam val_t RESET_LENIENT = 32'sd128451;
  localparam val_t RESET_GAP     = 32'sd131072;

  localparam logic [CFG_IDX_W-1:0] CFG_LENIENT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP     = 1'd1;

  typedef enum logic [1:0] {
    AS_BEST    = 2'd0,
    AS_NONE    = 2'd1,
    AS_LENIENT = 2'd2
  } assigned_t;

  typedef enum logic [2:0] {
    OV_UNCLEAR      = 3'd0,
    OV_SELF_BEST    = 3'd1,
    OV_SINGLE_NEW   = 3'd2,
    OV_SELF_LENIENT = 3'd3,
    OV_MULTI_NEW    = 3'd4
  } overall_t;

  typedef struct packed {
    logic [TOP_COUNT-1:0][VAL_W-1:0] scores;
    logic [TOP_COUNT-1:0][VAL_W-1:0] corrs;
    logic [TOP_COUNT-1:0][IDX_W-1:0] indices;
    logic [TOP_COUNT-1:0]            valid;
    logic [RANK_W-1:0]               rank;
    logic                            has_self;
    val_t                            self_score;
    val_t                            self_corr;
  } col_rec_t;

  function automatic val_t sat_add32(val_t a, val_t b);
    logic signed [VAL_W:0] s;
    s = $signed({a[VAL_W-1], a}) + $signed({b[VAL_W-1], b});
    if (s[VAL_W] != s[VAL_W-1]) begin
      sat_add32 = s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      sat_add32 = s[VAL_W-1:0];
    end
  endfunction

endpackage

// ----- rtl/tmsc_front.sv -----
// ----------------------------------------------------------------------------
// tmsc_front
// Scanner: keeps the five best candidates and the self rank, one request per
// cycle while in_acc is high, and hands a snapshot of the column to the queue on its last request.
// ----------------------------------------------------------------------------
module tmsc_front import tmsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_acc,
  input  logic [IDX_W-1:0]  in_cand_index,
  input  val_t              in_score,
  input  val_t              in_corr,
  input  logic              in_self_present,
  input  logic [IDX_W-1:0]  in_self_index,
  input  val_t              in_self_score,
  input  val_t              in_self_corr,
  input  logic              in_col_last,
  output logic              q_wr,
  output col_rec_t          q_wdata
);

  val_t              score_r [TOP_COUNT];
  val_t              corr_r  [TOP_COUNT];
  logic [IDX_W-1:0]  index_r [TOP_COUNT];
  logic [TOP_COUNT-1:0] valid_r;
  logic [RANK_W-1:0] rank_r;

  val_t              score_nxt [TOP_COUNT];
  val_t              corr_nxt  [TOP_COUNT];
  logic [IDX_W-1:0]  index_nxt [TOP_COUNT];
  logic [TOP_COUNT-1:0] valid_nxt;
  logic [RANK_W-1:0] rank_nxt;
  logic [TOP_COUNT-1:0] gt;
  logic              rank_inc;

  // slots stay non-increasing, so gt is a thermometer code
  always_comb begin
    for (int k = 0; k < TOP_COUNT; k++) begin
      gt[k] = in_score > score_r[k];
    end
    if (gt[0]) begin
      score_nxt[0] = in_score;
      corr_nxt[0]  = in_corr;
      index_nxt[0] = in_cand_index;
      valid_nxt[0] = 1'b1;
    end else begin
      score_nxt[0] = score_r[0];
      corr_nxt[0]  = corr_r[0];
      index_nxt[0] = index_r[0];
      valid_nxt[0] = valid_r[0];
    end
    for (int k = 1; k < TOP_COUNT; k++) begin
      if (gt[k] && !gt[k-1]) begin
        score_nxt[k] = in_score;
        corr_nxt[k]  = in_corr;
        index_nxt[k] = in_cand_index;
        valid_nxt[k] = 1'b1;
      end else if (gt[k]) begin
        score_nxt[k] = score_r[k-1];
        corr_nxt[k]  = corr_r[k-1];
        index_nxt[k] = index_r[k-1];
        valid_nxt[k] = valid_r[k-1];
      end else begin
        score_nxt[k] = score_r[k];
        corr_nxt[k]  = corr_r[k];
        index_nxt[k] = index_r[k];
        valid_nxt[k] = valid_r[k];
      end
    end
    rank_inc = in_self_present && (in_cand_index != in_self_index) &&
               (in_score > in_self_score) && (rank_r < RANK_W'(MAX_CANDIDATES));
    rank_nxt = rank_inc ? rank_r + RANK_W'(1) : rank_r;
  end

  always_comb begin
    for (int k = 0; k < TOP_COUNT; k++) begin
      q_wdata.scores[k]  = score_nxt[k];
      q_wdata.corrs[k]   = corr_nxt[k];
      q_wdata.indices[k] = index_nxt[k];
    end
    q_wdata.valid      = valid_nxt;
    q_wdata.rank       = rank_nxt;
    q_wdata.has_self   = in_self_present;
    q_wdata.self_score = in_self_score;
    q_wdata.self_corr  = in_self_corr;
  end

  assign q_wr = in_acc && in_col_last;

  always_ff @(posedge clk) begin
    if (!rst_n || q_wr) begin
      for (int k = 0; k < TOP_COUNT; k++) begin
        score_r[k] <= EMPTY_SCORE;
        corr_r[k]  <= EMPTY_SCORE;
        index_r[k] <= '0;
      end
      valid_r <= '0;
      rank_r  <= RANK_W'(1);
    end else if (in_acc) begin
      for (int k = 0; k < TOP_COUNT; k++) begin
        score_r[k] <= score_nxt[k];
        corr_r[k]  <= corr_nxt[k];
        index_r[k] <= index_nxt[k];
      end
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
    end
  end

endmodule

// ----- rtl/tmsc_queue.sv -----
// ----------------------------------------------------------------------------
// tmsc_queue
// Two-entry queue of finished column records between scanner and emitter.
// ----------------------------------------------------------------------------
module tmsc_queue import tmsc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr,
  input  col_rec_t wdata,
  input  logic     rd,
  output col_rec_t rdata,
  output logic     q_full,
  output logic     q_empty
);

  col_rec_t            entry_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic                do_wr;
  logic                do_rd;

  assign q_full  = cnt_r == QCNT_W'(QDEPTH);
  assign q_empty = cnt_r == '0;
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rdata   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/tmsc_back.sv -----
// ----------------------------------------------------------------------------
// tmsc_back
// Classifier and emitter: grades a column record and sends its five slots,
// one result request per cycle while pop is high. Holds the threshold registers.
// ----------------------------------------------------------------------------
module tmsc_back import tmsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data,
  input  logic                 q_empty,
  input  col_rec_t             q_rdata,
  output logic                 q_rd,
  input  logic                 pop,
  output logic                 empty,
  output logic [2:0]           out_slot,
  output logic                 out_slot_valid,
  output logic [IDX_W-1:0]     out_slot_index,
  output val_t                 out_slot_score,
  output val_t                 out_slot_corr,
  output logic                 out_has_self,
  output logic [RANK_W-1:0]    out_self_rank,
  output val_t                 out_self_score_out,
  output val_t                 out_self_corr_out,
  output logic [1:0]           out_assigned_status,
  output logic [2:0]           out_overall_status,
  output logic                 out_last
);

  val_t              lenient_r;
  val_t              gap_r;
  col_rec_t          cur_r;
  assigned_t         assigned_r;
  overall_t          overall_r;
  logic              busy_r;
  logic [SLOT_W-1:0] slot_r;

  assigned_t         assigned_nxt;
  overall_t          overall_nxt;
  logic              single_new;
  logic              multi_new;
  logic              slot_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lenient_r <= RESET_LENIENT;
      gap_r     <= RESET_GAP;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LENIENT: lenient_r <= cfg_data;
        CFG_GAP:     gap_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    single_new = $signed(q_rdata.scores[0]) > sat_add32(q_rdata.scores[1], gap_r);
    multi_new  = 1'b0;
    for (int k = 2; k < TOP_COUNT; k++) begin
      if ($signed(q_rdata.scores[k-1]) > sat_add32(q_rdata.scores[k], gap_r)) begin
        multi_new = 1'b1;
      end
    end

    if (!q_rdata.has_self) begin
      assigned_nxt = AS_NONE;
    end else if (q_rdata.rank == RANK_W'(1)) begin
      assigned_nxt = AS_BEST;
    end else if (q_rdata.self_score < lenient_r) begin
      assigned_nxt = AS_NONE;
    end else begin
      assigned_nxt = AS_LENIENT;
    end

    if (q_rdata.rank == RANK_W'(1)) begin
      overall_nxt = OV_SELF_BEST;
    end else if (single_new) begin
      overall_nxt = OV_SINGLE_NEW;
    end else if (multi_new) begin
      overall_nxt = OV_MULTI_NEW;
    end else if (q_rdata.self_score > lenient_r) begin
      overall_nxt = OV_SELF_LENIENT;
    end else begin
      overall_nxt = OV_UNCLEAR;
    end
  end

  assign slot_end = slot_r == SLOT_W'(TOP_COUNT - 1);
  assign q_rd     = !q_empty && (!busy_r || (pop && slot_end));

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur_r      <= q_rdata;
      assigned_r <= assigned_nxt;
      overall_r  <= overall_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      slot_r <= '0;
    end else if (q_rd) begin
      busy_r <= 1'b1;
      slot_r <= '0;
    end else if (busy_r && pop) begin
      if (slot_end) begin
        busy_r <= 1'b0;
      end else begin
        slot_r <= slot_r + SLOT_W'(1);
      end
    end
  end

  assign empty               = !busy_r;
  assign out_slot            = 3'(slot_r);
  assign out_slot_valid      = cur_r.valid[slot_r];
  assign out_slot_index      = cur_r.indices[slot_r];
  assign out_slot_score      = cur_r.scores[slot_r];
  assign out_slot_corr       = cur_r.corrs[slot_r];
  assign out_has_self        = cur_r.has_self;
  assign out_self_rank       = cur_r.rank;
  assign out_self_score_out  = cur_r.self_score;
  assign out_self_corr_out   = cur_r.self_corr;
  assign out_assigned_status = assigned_r;
  assign out_overall_status  = overall_r;
  assign out_last            = slot_end;

endmodule

// ----- rtl/top5_match_scan_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// top5_match_scan_classifier_unit
// Streaming top-5 score scan per column with self-rank classification.
// ----------------------------------------------------------------------------
// Throughput: one candidate per cycle unless full; five results a column, one per cycle on pop.
// A finished column record goes into a queue entry, then into the emitter's output register.
// The two-entry column queue stalls input (full) only when the emitter lags.
// Synchronous active-low reset: empty scan, rank one, default thresholds.
module top5_match_scan_classifier_unit import tmsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data,
  input  logic                 push,
  output logic                 full,
  input  logic [IDX_W-1:0]     in_cand_index,
  input  val_t                 in_score,
  input  val_t                 in_corr,
  input  logic                 in_self_present,
  input  logic [IDX_W-1:0]     in_self_index,
  input  val_t                 in_self_score,
  input  val_t                 in_self_corr,
  input  logic                 in_col_last,
  output logic                 empty,
  input  logic                 pop,
  output logic [2:0]           out_slot,
  output logic                 out_slot_valid,
  output logic [IDX_W-1:0]     out_slot_index,
  output val_t                 out_slot_score,
  output val_t                 out_slot_corr,
  output logic                 out_has_self,
  output logic [RANK_W-1:0]    out_self_rank,
  output val_t                 out_self_score_out,
  output val_t                 out_self_corr_out,
  output logic [1:0]           out_assigned_status,
  output logic [2:0]           out_overall_status,
  output logic                 out_last
);

  logic     in_acc;
  logic     q_wr;
  logic     q_rd;
  logic     q_full;
  logic     q_empty;
  col_rec_t q_wdata;
  col_rec_t q_rdata;

  assign full   = q_full;
  assign in_acc = push && !q_full;

  tmsc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_acc          (in_acc),
    .in_cand_index   (in_cand_index),
    .in_score        (in_score),
    .in_corr         (in_corr),
    .in_self_present (in_self_present),
    .in_self_index   (in_self_index),
    .in_self_score   (in_self_score),
    .in_self_corr    (in_self_corr),
    .in_col_last     (in_col_last),
    .q_wr            (q_wr),
    .q_wdata         (q_wdata)
  );

  tmsc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wdata   (q_wdata),
    .rd      (q_rd),
    .rdata   (q_rdata),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  tmsc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .q_empty             (q_empty),
    .q_rdata             (q_rdata),
    .q_rd                (q_rd),
    .pop                 (pop),
    .empty               (empty),
    .out_slot            (out_slot),
    .out_slot_valid      (out_slot_valid),
    .out_slot_index      (out_slot_index),
    .out_slot_score      (out_slot_score),
    .out_slot_corr       (out_slot_corr),
    .out_has_self        (out_has_self),
    .out_self_rank       (out_self_rank),
    .out_self_score_out  (out_self_score_out),
    .out_self_corr_out   (out_self_corr_out),
    .out_assigned_status (out_assigned_status),
    .out_overall_status  (out_overall_status),
    .out_last            (out_last)
  );

  a_empty_slot_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_slot_valid |-> out_slot_score == EMPTY_SCORE)
    else $error("empty slot without sentinel score");

  a_rank_one_self_best: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_self_rank == RANK_W'(1) |-> out_overall_status == OV_SELF_BEST)
    else $error("rank one not graded self best");

  a_slot_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && pop && !out_last |=> !empty && out_slot == $past(out_slot) + 3'd1)
    else $error("slot sequence broken");

  a_no_self_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_has_self |-> out_assigned_status == AS_NONE)
    else $error("no-self column not graded no match");

endmodule

// ----- tb/tb_top5_match_scan_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// tb_top5_match_scan_classifier_unit
// Self-checking bench for the top-5 column scanner. A directed table covers
// field extremes, ties, sentinel scores and every status code. Random columns
// follow, mostly well-formed and some with mixed per-item self fields, under
// several threshold settings.
// Every result is checked field by field against a local scan predictor.
// ----------------------------------------------------------------------------
module tb_top5_match_scan_classifier_unit import tmsc_pkg::*; ();

  localparam int   LIMIT  = 1000000;
  localparam int   N_DIR  = 25;
  localparam val_t MAXV   = 32'sh7FFF_FFFF;
  localparam val_t MINV   = 32'sh8000_0000;
  localparam val_t Q1     = 32'sd65536;

  typedef struct packed {
    logic [IDX_W-1:0] cand_index;
    val_t             score;
    val_t             corr;
    logic             self_present;
    logic [IDX_W-1:0] self_index;
    val_t             self_score;
    val_t             self_corr;
    logic             col_last;
  } cand_req_t;

  typedef struct packed {
    logic [2:0]        slot;
    logic              valid;
    logic [IDX_W-1:0]  index;
    val_t              score;
    val_t              corr;
    logic              has_self;
    logic [RANK_W-1:0] rank;
    val_t              self_score;
    val_t              self_corr;
    assigned_t         assigned;
    overall_t          overall;
    logic              last;
  } slot_result_t;

  typedef struct packed {
    cand_req_t         req;
    logic              typed;
    logic [RANK_W-1:0] rank;
    assigned_t         assigned;
    overall_t          overall;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VAL_W-1:0]     cfg_data;
  logic                 push;
  logic                 full;
  logic [IDX_W-1:0]     in_cand_index;
  val_t                 in_score;
  val_t                 in_corr;
  logic                 in_self_present;
  logic [IDX_W-1:0]     in_self_index;
  val_t                 in_self_score;
  val_t                 in_self_corr;
  logic                 in_col_last;
  logic                 empty;
  logic                 pop;
  logic [2:0]           out_slot;
  logic                 out_slot_valid;
  logic [IDX_W-1:0]     out_slot_index;
  val_t                 out_slot_score;
  val_t                 out_slot_corr;
  logic                 out_has_self;
  logic [RANK_W-1:0]    out_self_rank;
  val_t                 out_self_score_out;
  val_t                 out_self_corr_out;
  logic [1:0]           out_assigned_status;
  logic [2:0]           out_overall_status;
  logic                 out_last;

  top5_match_scan_classifier_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .push                (push),
    .full                (full),
    .in_cand_index       (in_cand_index),
    .in_score            (in_score),
    .in_corr             (in_corr),
    .in_self_present     (in_self_present),
    .in_self_index       (in_self_index),
    .in_self_score       (in_self_score),
    .in_self_corr        (in_self_corr),
    .in_col_last         (in_col_last),
    .empty               (empty),
    .pop                 (pop),
    .out_slot            (out_slot),
    .out_slot_valid      (out_slot_valid),
    .out_slot_index      (out_slot_index),
    .out_slot_score      (out_slot_score),
    .out_slot_corr       (out_slot_corr),
    .out_has_self        (out_has_self),
    .out_self_rank       (out_self_rank),
    .out_self_score_out  (out_self_score_out),
    .out_self_corr_out   (out_self_corr_out),
    .out_assigned_status (out_assigned_status),
    .out_overall_status  (out_overall_status),
    .out_last            (out_last)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---- scan predictor state ----
  val_t              top_score [TOP_COUNT];
  val_t              top_corr  [TOP_COUNT];
  logic [IDX_W-1:0]  top_index [TOP_COUNT];
  logic              top_full  [TOP_COUNT];
  int unsigned       rank_cnt;
  val_t              thr_lenient;
  val_t              gap_clear;

  slot_result_t      pending_results [$];
  slot_result_t      seen;
  slot_result_t      want;
  int                mismatches;
  int                cycle_cnt;
  bit                idle_on;
  int                rx_hold;

  dir_row_t dir_tab [N_DIR] = '{
    // single item, no self, field extremes
    '{'{16'hFFFF, MAXV, MINV, 1'b0, 16'h0000, 32'sd0, 32'sd0, 1'b1},
      1'b1, 17'd1, AS_NONE, OV_SELF_BEST},
    // scores at and below the sentinel never land in a slot
    '{'{16'd1, EMPTY_SCORE, MAXV, 1'b0, 16'd0, 32'sd0, 32'sd0, 1'b0},
      1'b0, 17'd0, AS_BEST, OV_UNCLEAR},
    '{'{16'd2, MINV, 32'sd0, 1'b0, 16'd0, 32'sd0, 32'sd0, 1'b1},
      1'b1, 17'd1, AS_NONE, OV_SELF_BEST},
    // self on top, tie with self is not above it
    '{'{16'hFFFF, 32'sd196608, 32'sd1, 1'b1, 16'hFFFF, 32'sd196608, MAXV, 1'b0},
      1'b0, 17'd0, AS_BEST, OV_UNCLEAR},
    '{'{16'd0, 32'sd196608, 32'sd2, 1'b1, 16'hFFFF, 32'sd196608, MAXV, 1'b0},
      1'b0, 17'd0, AS_BEST, OV_UNCLEAR},
    '{'{16'd3, Q1, 32'sd3, 1'b1, 16'hFFFF, 32'sd196608, MAXV, 1'b1},
      1'b1, 17'd1, AS_BEST, OV_SELF_BEST},
    // self low: no match, clear single new best
    '{'{16'd7, 32'sd0, 32'sd5, 1'b1, 16'd7, 32'sd0, -32'sd1, 1'b0},
      1'b0, 17'd0, AS_BEST, OV_UNCLEAR},
    '{'{16'd1, 32'sd655360, 32'sd6, 1'b1, 16'd7, 32'sd0, -32'sd1, 1'b0},
      1'b0, 17'd0, AS_BEST, OV_UNCLEAR},
    '{'{16'd2, Q1, 32'sd7, 1'b1, 16'd7, 32'sd0, -32'sd1, 1'b1},
      1'b1, 17'd3, AS_NONE, OV_SINGLE_NEW},
    // seven items, shift-down past the fifth slot, lenient self
    '{'{16'd1, 32'sd262144, -32'sd11, 1'b1, 16'd9, 32'sd163840, 32'sd99, 1'b0},
      1'b0, 17'd0, AS_BEST, OV_UNCLEAR},
    '{'{16'd2, 32'sd229376, -32'sd12, 1'b1, 16'd9, 32'sd163840, 32'sd99, 1'b0},
      1'b0, 17'd0, AS_BEST, OV_UNCLEAR},
    '{'{16'd9, 32'sd163840, 32'sd99, 1'b1, 16'd9, 32'sd163840, 32'sd99, 1'b0},
      1'b0, 17'd0, AS_BEST, OV_UNCLEAR},
    '{'{16'd3, 32'sd196608, -32'sd13, 1'b1, 16'd9, 32'sd163840, 32'sd99, 1'b0},
      1'b0, 17'd0, AS_BEST, OV_UNCLEAR},
    '{'{16'd4, 32'sd180224, -32'sd14, 1'b1, 16'd9, 32'sd163840, 32'sd99, 1'b0},
      1'b0, 17'd0, AS_BEST, OV_UNCLEAR},
    '{'{16'd5, 32'sd170394, -32'sd15, 1'b1, 16'd9, 32'sd163840, 32'sd99, 1'b0},
      1'b0, 17'd0, AS_BEST, OV_UNCLEAR},
    '{'{16'd6, Q1, -32'sd16, 1'b1, 16'd9, 32'sd163840, 32'sd99, 1'b1},
      1'b1, 17'd6, AS_LENIENT, OV_SELF_LENIENT},
    // self equal to threshold; empty slot gap overrides
    '{'{16'd0, 32'sd128451, 32'sd21, 1'b1, 16'd0, 32'sd128451, 32'sd21, 1'b0},
      1'b0, 17'd0, AS_BEST, OV_UNCLEAR},
    '{'{16'd1, 32'sd128452, 32'sd22, 1'b1, 16'd0, 32'sd128451, 32'sd21, 1'b1},
      1'b1, 17'd2, AS_LENIENT, OV_MULTI_NEW},
    // full slots, small gaps, self below threshold
    '{'{16'd1, Q1, 32'sd31, 1'b1, 16'd0, 32'sd0, 32'sd0, 1'b0},
      1'b0, 17'd0, AS_BEST, OV_UNCLEAR},
    '{'{16'd2, 32'sd98304, 32'sd32, 1'b1, 16'd0, 32'sd0, 32'sd0, 1'b0},
      1'b0, 17'd0, AS_BEST, OV_UNCLEAR},
    '{'{16'd3, 32'sd131072, 32'sd33, 1'b1, 16'd0, 32'sd0, 32'sd0, 1'b0},
      1'b0, 17'd0, AS_BEST, OV_UNCLEAR},
    '{'{16'd4, 32'sd163840, 32'sd34, 1'b1, 16'd0, 32'sd0, 32'sd0, 1'b0},
      1'b0, 17'd0, AS_BEST, OV_UNCLEAR},
    '{'{16'd5, 32'sd196608, 32'sd35, 1'b1, 16'd0, 32'sd0, 32'sd0, 1'b1},
      1'b1, 17'd6, AS_NONE, OV_UNCLEAR},
    // self fields differ per item; echo comes from the last one
    '{'{16'd1, Q1, 32'sd41, 1'b1, 16'd0, 32'sd0, 32'sd0, 1'b0},
      1'b0, 17'd0, AS_BEST, OV_UNCLEAR},
    '{'{16'd2, 32'sd327680, 32'sd42, 1'b0, 16'hABCD, -32'sd5, 32'sd77, 1'b1},
      1'b0, 17'd0, AS_BEST, OV_UNCLEAR}
  };

  function automatic val_t add_clamped(val_t a, val_t b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > longint'(MAXV)) return MAXV;
    if (s < longint'(MINV)) return MINV;
    return val_t'(s);
  endfunction

  function automatic void clear_scan();
    for (int k = 0; k < TOP_COUNT; k++) begin
      top_score[k] = EMPTY_SCORE;
      top_corr[k]  = EMPTY_SCORE;
      top_index[k] = '0;
      top_full[k]  = 1'b0;
    end
    rank_cnt = 1;
  endfunction

  function automatic void scan_candidate(cand_req_t rq);
    bit           placed;
    val_t         sc;
    assigned_t    as_code;
    overall_t     ov_code;
    slot_result_t r;
    sc = rq.score;
    placed = 1'b0;
    if (rq.self_present && rq.cand_index != rq.self_index &&
        $signed(sc) > $signed(rq.self_score) && rank_cnt < MAX_CANDIDATES)
      rank_cnt++;
    for (int k = 0; k < TOP_COUNT; k++) begin
      if (!placed && $signed(sc) > $signed(top_score[k])) begin
        for (int l = TOP_COUNT - 1; l > k; l--) begin
          top_score[l] = top_score[l-1];
          top_corr[l]  = top_corr[l-1];
          top_index[l] = top_index[l-1];
          top_full[l]  = top_full[l-1];
        end
        top_score[k] = sc;
        top_corr[k]  = rq.corr;
        top_index[k] = rq.cand_index;
        top_full[k]  = 1'b1;
        placed = 1'b1;
      end
    end
    if (!rq.col_last) return;

    if (!rq.self_present) as_code = AS_NONE;
    else if (rank_cnt == 1) as_code = AS_BEST;
    else if ($signed(rq.self_score) < $signed(thr_lenient)) as_code = AS_NONE;
    else as_code = AS_LENIENT;

    ov_code = OV_UNCLEAR;
    if (rank_cnt == 1) begin
      ov_code = OV_SELF_BEST;
    end else if ($signed(top_score[0]) > $signed(add_clamped(top_score[1], gap_clear))) begin
      ov_code = OV_SINGLE_NEW;
    end else begin
      if ($signed(rq.self_score) > $signed(thr_lenient)) ov_code = OV_SELF_LENIENT;
      for (int k = 2; k < TOP_COUNT; k++)
        if ($signed(top_score[k-1]) > $signed(add_clamped(top_score[k], gap_clear)))
          ov_code = OV_MULTI_NEW;
    end

    for (int n = 0; n < TOP_COUNT; n++) begin
      r.slot       = 3'(n);
      r.valid      = top_full[n];
      r.index      = top_index[n];
      r.score      = top_score[n];
      r.corr       = top_corr[n];
      r.has_self   = rq.self_present;
      r.rank       = RANK_W'(rank_cnt);
      r.self_score = rq.self_score;
      r.self_corr  = rq.self_corr;
      r.assigned   = as_code;
      r.overall    = ov_code;
      r.last       = (n == TOP_COUNT - 1);
      pending_results.insert(pending_results.size(), r);
    end
    clear_scan();
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic val_t rand_score(val_t near);
    longint v;
    case ($urandom_range(0, 9))
      0: return val_t'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: return MAXV;
          1: return MINV;
          2: return EMPTY_SCORE;
          3: return EMPTY_SCORE + 32'sd1;
          default: return EMPTY_SCORE - 32'sd1;
        endcase
      end
      2, 3, 4, 5: v = longint'(near) + longint'($urandom_range(0, 524288)) - 262144;
      default: v = longint'($urandom_range(0, 1048576)) - 524288;
    endcase
    if (v > longint'(MAXV)) v = longint'(MAXV);
    if (v < longint'(MINV)) v = longint'(MINV);
    return val_t'(v);
  endfunction

  function automatic string fmt_result(slot_result_t r);
    return $sformatf({"slot %0d v %0b idx %h sc %h co %h hs %0b rk %0d ",
                      "ss %h sco %h as %0d ov %0d l %0b"},
                     r.slot, r.valid, r.index, r.score, r.corr, r.has_self, r.rank,
                     r.self_score, r.self_corr, r.assigned, r.overall, r.last);
  endfunction

  task automatic note_mismatch(string what, slot_result_t w, slot_result_t g);
    mismatches++;
    if (mismatches <= 10)
      $display("%0s\n  expected %0s\n  actual   %0s", what, fmt_result(w), fmt_result(g));
  endtask

  task automatic send_request(cand_req_t rq);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_cand_index   <= rq.cand_index;
    in_score        <= rq.score;
    in_corr         <= rq.corr;
    in_self_present <= rq.self_present;
    in_self_index   <= rq.self_index;
    in_self_score   <= rq.self_score;
    in_self_corr    <= rq.self_corr;
    in_col_last     <= rq.col_last;
    push            <= 1'b1;
    do @(posedge clk); while (full);
    scan_candidate(rq);
    @(negedge clk);
  endtask

  task automatic set_thresholds(val_t lenient, val_t gap);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LENIENT;
    cfg_data  <= lenient;
    @(negedge clk);
    cfg_index <= CFG_GAP;
    cfg_data  <= gap;
    @(negedge clk);
    cfg_we    <= 1'b0;
    thr_lenient = lenient;
    gap_clear   = gap;
  endtask

  task automatic drain_results();
    wait (pending_results.size() == 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic run_random_column(output int count);
    int        len;
    int        self_pos;
    cand_req_t rq;
    logic      sp;
    logic [IDX_W-1:0] sidx;
    val_t      ss;
    val_t      sco;
    val_t      prev_score;
    len = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 6);
    sp = ($urandom_range(0, 4) != 0);
    sidx = IDX_W'($urandom);
    ss = ($urandom_range(0, 7) == 0) ? thr_lenient : rand_score(thr_lenient);
    sco = val_t'($urandom);
    self_pos = ($urandom_range(0, 4) != 0) ? int'($urandom_range(0, len - 1)) : -1;
    idle_on = ($urandom_range(0, 3) != 0);
    prev_score = ss;
    for (int k = 0; k < len; k++) begin
      rq.self_present = sp;
      rq.self_index   = sidx;
      rq.self_score   = ss;
      rq.self_corr    = sco;
      rq.cand_index   = IDX_W'($urandom);
      rq.score        = ($urandom_range(0, 7) == 0) ? prev_score : rand_score(ss);
      rq.corr         = val_t'($urandom);
      if (k == self_pos) begin
        rq.cand_index = sidx;
        rq.score      = ss;
        rq.corr       = sco;
      end
      // noise: self fields that disagree within the column
      if ($urandom_range(0, 9) == 0) begin
        rq.self_present = 1'($urandom);
        rq.self_index   = IDX_W'($urandom);
        rq.self_score   = val_t'($urandom);
        rq.self_corr    = val_t'($urandom);
      end
      if ($urandom_range(0, 15) == 0) rq.cand_index = rq.self_index;
      rq.col_last = (k == len - 1);
      prev_score = rq.score;
      send_request(rq);
    end
    count = len;
  endtask

  // result side: random pop stalls
  initial begin
    pop = 1'b0;
    rx_hold = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        pop <= 1'b0;
        rx_hold--;
      end else begin
        pop <= 1'b1;
        rx_hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      seen.slot       = out_slot;
      seen.valid      = out_slot_valid;
      seen.index      = out_slot_index;
      seen.score      = out_slot_score;
      seen.corr       = out_slot_corr;
      seen.has_self   = out_has_self;
      seen.rank       = out_self_rank;
      seen.self_score = out_self_score_out;
      seen.self_corr  = out_self_corr_out;
      seen.assigned   = assigned_t'(out_assigned_status);
      seen.overall    = overall_t'(out_overall_status);
      seen.last       = out_last;
      if (pending_results.size() == 0) begin
        note_mismatch("result with no request pending", seen, seen);
      end else begin
        want = pending_results.pop_front();
        if (seen.slot !== want.slot || seen.valid !== want.valid ||
            seen.index !== want.index || seen.score !== want.score ||
            seen.corr !== want.corr || seen.has_self !== want.has_self ||
            seen.rank !== want.rank || seen.self_score !== want.self_score ||
            seen.self_corr !== want.self_corr || seen.assigned !== want.assigned ||
            seen.overall !== want.overall || seen.last !== want.last)
          note_mismatch("result mismatch", want, seen);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("tb_top5_match_scan_classifier_unit: done, errors");
      $finish;
    end
  end

  initial begin
    int        done;
    int        n;
    bit        paused;
    int        base;

    mismatches = 0;
    cycle_cnt = 0;
    paused = 1'b0;
    idle_on = 1'b1;
    thr_lenient = RESET_LENIENT;
    gap_clear = RESET_GAP;
    clear_scan();

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    push = 1'b0;
    in_cand_index = '0;
    in_score = '0;
    in_corr = '0;
    in_self_present = 1'b0;
    in_self_index = '0;
    in_self_score = '0;
    in_self_corr = '0;
    in_col_last = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < N_DIR; r++) begin
      send_request(dir_tab[r].req);
      if (dir_tab[r].typed) begin
        base = pending_results.size() - TOP_COUNT;
        for (int k = base; k < base + TOP_COUNT; k++) begin
          pending_results[k].rank     = dir_tab[r].rank;
          pending_results[k].assigned = dir_tab[r].assigned;
          pending_results[k].overall  = dir_tab[r].overall;
        end
      end
    end
    push <= 1'b0;
    drain_results();

    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        drain_results();
        case (ph)
          1: set_thresholds(MAXV, MAXV);
          2: set_thresholds(MINV, MINV);
          3: set_thresholds(32'sd0, 32'sd0);
          4: set_thresholds(val_t'($urandom), val_t'($urandom));
          5: set_thresholds(val_t'(longint'($urandom_range(0, 524288)) - 262144),
                            val_t'(longint'($urandom_range(0, 262144))));
          default: set_thresholds(RESET_LENIENT, RESET_GAP);
        endcase
      end
      done = 0;
      while (done < 60) begin
        run_random_column(n);
        done += n;
        if (ph == 3 && !paused && done > 30) begin
          push <= 1'b0;
          wait (pending_results.size() == 0);
          @(negedge clk);
          paused = 1'b1;
        end
      end
      push <= 1'b0;
    end

    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top5_match_scan_classifier_unit: done, clean");
    end else begin
      $display("tb_top5_match_scan_classifier_unit: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/tmsc_pkg.sv
rtl/tmsc_front.sv
rtl/tmsc_queue.sv
rtl/tmsc_back.sv
rtl/top5_match_scan_classifier_unit.sv
tb/tb_top5_match_scan_classifier_unit.sv
